// ===== rtl/lltp_pkg.sv =====
// ----------------------------------------------------------------------------
// lltp_pkg
// Shared types and constants of the least-loaded task placer.
// ----------------------------------------------------------------------------
package lltp_pkg;

    localparam int MAX_NODES    = 8;
    localparam int TABLE_DEPTH  = 64;
    localparam int TASK_ID_BITS = 22;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int NODE_W  = 3;
    localparam int LOAD_W  = 7;
    localparam int CPN_W   = 7;
    localparam int NCNT_W  = 4;
    localparam int CPU_W   = 9;
    localparam int PADDR_W = 3;

    localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};
    localparam logic [CPN_W-1:0]  CPN_MAX  = CPN_W'(64);

    // Action codes.
    localparam logic ACT_ARRIVE = 1'b0;
    localparam logic ACT_DEPART = 1'b1;

    // Register select (byte address bit 2).
    localparam logic REG_CPN = 1'b0;
    localparam logic REG_NC  = 1'b1;

    typedef enum logic [2:0] {
        ST_PLACED    = 3'd0,
        ST_RELEASED  = 3'd1,
        ST_PRESENT   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic        action;
        logic [21:0] task_id;
    } t_req;

    typedef struct packed {
        logic [2:0] node;
        logic [8:0] cpu_first;
        logic [8:0] cpu_last;
        t_status    status;
    } t_res;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic last;
    } t_stat;

endpackage

// ===== rtl/lltp_ctrl.sv =====
// ----------------------------------------------------------------------------
// lltp_ctrl
// Sequencer: accept an event, walk the task table, drain, commit.
// ----------------------------------------------------------------------------
module lltp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  lltp_pkg::t_stat i_stat,
    output lltp_pkg::t_cmd  o_cmd,
    output logic            o_busy
);

    lltp_pkg::t_state r_state;
    lltp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lltp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lltp_pkg::S_IDLE: begin
                if (i_start) n_state = lltp_pkg::S_SCAN;
            end
            lltp_pkg::S_SCAN: begin
                if (i_stat.last) n_state = lltp_pkg::S_DRAIN;
            end
            lltp_pkg::S_DRAIN: n_state = lltp_pkg::S_EXEC;
            lltp_pkg::S_EXEC:  n_state = lltp_pkg::S_IDLE;
            default:           n_state = lltp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            lltp_pkg::S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            lltp_pkg::S_SCAN:  o_cmd.rd_en  = 1'b1;
            lltp_pkg::S_DRAIN: o_cmd.commit = 1'b0;
            lltp_pkg::S_EXEC:  o_cmd.commit = 1'b1;
            default:           o_busy = 1'b1;
        endcase
    end

`ifndef SYNTHESIS
    a_exec_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lltp_pkg::S_EXEC |=> r_state == lltp_pkg::S_IDLE)
        else $error("commit state not left after one cycle");
    a_drain_before_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lltp_pkg::S_EXEC |-> $past(r_state) == lltp_pkg::S_DRAIN)
        else $error("commit reached without draining the compare stage");
    a_busy_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy == (r_state != lltp_pkg::S_IDLE))
        else $error("busy does not match the sequencer state");
`endif

endmodule

// ===== rtl/lltp_dp.sv =====
// ----------------------------------------------------------------------------
// lltp_dp
// Datapath: task table, valid bits, node loads, scan compare and result.
// ----------------------------------------------------------------------------
module lltp_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lltp_pkg::t_cmd                    i_cmd,
    output lltp_pkg::t_stat                   o_stat,
    input  lltp_pkg::t_req                    i_req,
    input  logic [lltp_pkg::CPN_W-1:0]        i_cpn,
    input  logic [lltp_pkg::NCNT_W-1:0]       i_nc,
    output logic                              o_done,
    output lltp_pkg::t_res                    o_res
);

    // Table memory, one read port walked by the scan.
    logic [lltp_pkg::TASK_ID_BITS-1:0] r_mem_task [lltp_pkg::TABLE_DEPTH];
    logic [lltp_pkg::NODE_W-1:0]       r_mem_node [lltp_pkg::TABLE_DEPTH];

    logic                              r_action;
    logic [lltp_pkg::TASK_ID_BITS-1:0] r_id;
    logic [lltp_pkg::IDX_W-1:0]        r_addr;
    logic                              r_cmp_vld;
    logic [lltp_pkg::IDX_W-1:0]        r_rd_idx;
    logic [lltp_pkg::TASK_ID_BITS-1:0] r_rd_task;
    logic [lltp_pkg::NODE_W-1:0]       r_rd_node;
    logic                              r_hit_found;
    logic [lltp_pkg::IDX_W-1:0]        r_hit_idx;
    logic [lltp_pkg::NODE_W-1:0]       r_hit_node;
    logic                              r_free_found;
    logic [lltp_pkg::IDX_W-1:0]        r_free_idx;
    logic [lltp_pkg::TABLE_DEPTH-1:0]  r_valid;
    logic [lltp_pkg::LOAD_W-1:0]       r_load [lltp_pkg::MAX_NODES];
    logic                              r_done;
    lltp_pkg::t_res                    r_res;

    logic [lltp_pkg::NCNT_W-1:0] w_used;
    logic [lltp_pkg::CPN_W-1:0]  w_cpn;
    logic [lltp_pkg::NODE_W-1:0] w_best;
    logic                        w_place;
    logic                        w_release;
    logic                        w_rd_valid;
    lltp_pkg::t_res              w_res;

    assign o_stat.last = (r_addr == lltp_pkg::IDX_W'(lltp_pkg::TABLE_DEPTH - 1));
    assign w_rd_valid  = r_valid[r_rd_idx];

    // Capture event and run the scan / compare stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld    <= 1'b0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_addr       <= '0;
        end else if (i_cmd.load) begin
            r_cmp_vld    <= 1'b0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_addr       <= '0;
        end else begin
            r_cmp_vld <= i_cmd.rd_en;
            if (i_cmd.rd_en) r_addr <= r_addr + 1'b1;
            if (r_cmp_vld) begin
                if (w_rd_valid && !r_hit_found && r_rd_task == r_id) begin
                    r_hit_found <= 1'b1;
                end
                if (!w_rd_valid && !r_free_found) begin
                    r_free_found <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_req.action;
            r_id     <= i_req.task_id[lltp_pkg::TASK_ID_BITS-1:0];
        end
        if (r_cmp_vld && w_rd_valid && !r_hit_found && r_rd_task == r_id) begin
            r_hit_idx  <= r_rd_idx;
            r_hit_node <= r_rd_node;
        end
        if (r_cmp_vld && !w_rd_valid && !r_free_found) begin
            r_free_idx <= r_rd_idx;
        end
    end

    // Memory write on placement, registered read during the scan.
    always_ff @(posedge i_clk) begin
        if (w_place) begin
            r_mem_task[r_free_idx] <= r_id;
            r_mem_node[r_free_idx] <= w_best;
        end
        if (i_cmd.rd_en) begin
            r_rd_task <= r_mem_task[r_addr];
            r_rd_node <= r_mem_node[r_addr];
            r_rd_idx  <= r_addr;
        end
    end

    // Clamp configuration.
    always_comb begin
        priority if (i_nc == '0) begin
            w_used = lltp_pkg::NCNT_W'(1);
        end else if (i_nc > lltp_pkg::NCNT_W'(lltp_pkg::MAX_NODES)) begin
            w_used = lltp_pkg::NCNT_W'(lltp_pkg::MAX_NODES);
        end else begin
            w_used = i_nc;
        end
        priority if (i_cpn == '0) begin
            w_cpn = lltp_pkg::CPN_W'(1);
        end else if (i_cpn > lltp_pkg::CPN_MAX) begin
            w_cpn = lltp_pkg::CPN_MAX;
        end else begin
            w_cpn = i_cpn;
        end
    end

    // Least loaded node, lowest index on a tie.
    always_comb begin
        w_best = '0;
        for (int k = 1; k < lltp_pkg::MAX_NODES; k++) begin
            if (lltp_pkg::NCNT_W'(k) < w_used && r_load[k] < r_load[w_best]) begin
                w_best = lltp_pkg::NODE_W'(k);
            end
        end
    end

    assign w_place   = i_cmd.commit && r_action == lltp_pkg::ACT_ARRIVE
                       && !r_hit_found && r_free_found;
    assign w_release = i_cmd.commit && r_action == lltp_pkg::ACT_DEPART && r_hit_found;

    always_comb begin
        logic [lltp_pkg::CPU_W-1:0] first;
        logic                       with_range;
        w_res      = '0;
        with_range = 1'b1;
        if (r_action == lltp_pkg::ACT_ARRIVE) begin
            priority if (r_hit_found) begin
                w_res.node   = r_hit_node;
                w_res.status = lltp_pkg::ST_PRESENT;
            end else if (!r_free_found) begin
                with_range   = 1'b0;
                w_res.status = lltp_pkg::ST_FULL;
            end else begin
                w_res.node   = w_best;
                w_res.status = lltp_pkg::ST_PLACED;
            end
        end else begin
            if (r_hit_found) begin
                w_res.node   = r_hit_node;
                w_res.status = lltp_pkg::ST_RELEASED;
            end else begin
                with_range   = 1'b0;
                w_res.status = lltp_pkg::ST_NOT_FOUND;
            end
        end
        first = lltp_pkg::CPU_W'(w_res.node) * lltp_pkg::CPU_W'(w_cpn);
        if (with_range) begin
            w_res.cpu_first = first;
            w_res.cpu_last  = first + lltp_pkg::CPU_W'(w_cpn) - 1'b1;
        end
    end

    // Commit: valid bits, loads, result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_done  <= 1'b0;
            for (int k = 0; k < lltp_pkg::MAX_NODES; k++) begin
                r_load[k] <= '0;
            end
        end else begin
            r_done <= i_cmd.commit;
            if (w_place)   r_valid[r_free_idx] <= 1'b1;
            if (w_release) r_valid[r_hit_idx]  <= 1'b0;
            for (int k = 0; k < lltp_pkg::MAX_NODES; k++) begin
                if (w_place && w_best == lltp_pkg::NODE_W'(k)
                    && r_load[k] != lltp_pkg::LOAD_MAX) begin
                    r_load[k] <= r_load[k] + 1'b1;
                end
                if (w_release && r_hit_node == lltp_pkg::NODE_W'(k) && r_load[k] != '0) begin
                    r_load[k] <= r_load[k] - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) r_res <= w_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

`ifndef SYNTHESIS
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> !r_cmp_vld)
        else $error("commit while a table read is still in flight");
    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && r_hit_found |-> r_valid[r_hit_idx])
        else $error("matched entry is not valid at commit");
    a_free_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && r_free_found |-> !r_valid[r_free_idx])
        else $error("free entry is occupied at commit");
`endif

endmodule

// ===== rtl/least_loaded_task_placer.sv =====
// ----------------------------------------------------------------------------
// least_loaded_task_placer
// Places arriving tasks on the least loaded node and releases departing ones.
// ----------------------------------------------------------------------------
// Usage:
//   Event channel: drive i_req (action, task_id) with start high; the event
//   transfers at the clock edge where start is high and busy is low.
//   Result channel: o_done pulses for one cycle with o_res (node, CPU range,
//   status). The receiver cannot stall; every event yields one result.
//   Config: APB-style port, cpus_per_node at 0x0, node_count at 0x4, to be
//   written only while the block is idle (unenforced). pready is tied high.
// Timing:
//   The task table has one read port and is walked one entry per cycle
//   in the scan state, then a drain state for the registered compare and
//   a commit state. o_done is high in the cycle after the commit state;
//   busy is low in that same result cycle, so the next event can transfer
//   at the result edge. No new event is taken while busy is high.
// Reset (synchronous, active low): clears all table valid bits and node
//   loads at once, cpus_per_node to 1 and node_count to 8.
// ----------------------------------------------------------------------------
module least_loaded_task_placer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Event channel
    input  logic                          start,
    output logic                          busy,
    input  lltp_pkg::t_req                i_req,
    // Result channel
    output logic                          o_done,
    output lltp_pkg::t_res                o_res,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lltp_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [lltp_pkg::CPN_W-1:0]  r_cpn;
    logic [lltp_pkg::NCNT_W-1:0] r_nc;
    logic                        w_wr;

    lltp_pkg::t_cmd  w_cmd;
    lltp_pkg::t_stat w_stat;

    // Register write on the access phase; the register sits at paddr bit 2.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpn <= lltp_pkg::CPN_W'(1);
            r_nc  <= lltp_pkg::NCNT_W'(8);
        end else if (w_wr) begin
            unique case (paddr[2])
                lltp_pkg::REG_CPN: r_cpn <= pwdata[lltp_pkg::CPN_W-1:0];
                lltp_pkg::REG_NC:  r_nc  <= pwdata[lltp_pkg::NCNT_W-1:0];
                default:           r_cpn <= r_cpn;
            endcase
        end
    end

    // Readback of the raw register values.
    always_comb begin
        unique case (paddr[2])
            lltp_pkg::REG_CPN: prdata = {{(32 - lltp_pkg::CPN_W){1'b0}}, r_cpn};
            lltp_pkg::REG_NC:  prdata = {{(32 - lltp_pkg::NCNT_W){1'b0}}, r_nc};
            default:           prdata = '0;
        endcase
    end

    // Sequencer: idle, table walk, drain, commit.
    lltp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // Table, loads and result register.
    lltp_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_req   (i_req),
        .i_cpn   (r_cpn),
        .i_nc    (r_nc),
        .o_done  (o_done),
        .o_res   (o_res)
    );

endmodule
